@@ rtl/bsrf_pkg.sv @@
// Shared types and constants for the banked stack register file.
package bsrf_pkg;

    // Register file geometry
    localparam int unsigned DEFAULT_REGISTER_COUNT = 16;
    localparam int unsigned WORD_W                 = 32;
    localparam int unsigned INDEX_W                = 8;
    localparam int unsigned KIND_W                 = 3;

    // Architectural register numbers and masks
    localparam int unsigned PC_INDEX    = 15;
    localparam int unsigned SP_INDEX    = 13;
    localparam logic [WORD_W-1:0] SP_LOW_MASK = WORD_W'(32'h3);
    localparam int unsigned SPSEL_BIT   = 1;
    localparam logic [WORD_W-1:0] PC_OFFSET   = WORD_W'(32'd4);

    // Status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // Access kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_RD_GPR  = 3'd0,
        KIND_WR_GPR  = 3'd1,
        KIND_RD_PSR  = 3'd2,
        KIND_WR_PSR  = 3'd3,
        KIND_RD_CTRL = 3'd4,
        KIND_WR_CTRL = 3'd5
    } t_kind;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Command beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] reg_index;
        logic [WORD_W-1:0]  write_value;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic              status;
    } t_out_beat;

endpackage

@@ rtl/bsrf_gpr_bank.sv @@
// General register memory: one sync read port, one write port, reset-cleared valid bits.
module bsrf_gpr_bank #(
    parameter int unsigned REGISTER_COUNT = bsrf_pkg::DEFAULT_REGISTER_COUNT,
    parameter int unsigned AW             = $clog2(REGISTER_COUNT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [bsrf_pkg::WORD_W-1:0] o_rd_data,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [bsrf_pkg::WORD_W-1:0] i_wr_data
);
    import bsrf_pkg::*;

    logic [WORD_W-1:0]         r_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_valid;
    logic [WORD_W-1:0]         r_rd_data;
    logic                      r_rd_hit;

    // Storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

    // Sequencer never reads and writes in the same cycle
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd_en && i_wr_en))
        else $error("bank read and write in same cycle");

    // Addresses stay inside the array
    a_rd_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> (32'(i_rd_addr) < REGISTER_COUNT))
        else $error("bank read address out of range");

    a_wr_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> (32'(i_wr_addr) < REGISTER_COUNT))
        else $error("bank write address out of range");

endmodule

@@ rtl/banked_stack_register_file_unit.sv @@
// Top level of the banked stack register file: sequencer, PSR/CONTROL and SP banks.
//
//  Channel   Direction  Ports                   Handshake
//  command   in         start, busy, i_cmd      beat taken when start && !busy
//  result    out        o_strobe, o_result      beat valid for the one cycle o_strobe is high
//
//  Each command is accepted in ST_IDLE, which issues the register memory read; the
//  next cycle (ST_EXEC, busy high) computes and writes back. The registered result
//  appears the cycle after that, while the next command may already be accepted, so a
//  new command can be taken while its predecessor's result is presented.
//  Reset is synchronous; after reset all registers read as zero and no clear pass runs.
//  The result side cannot stall; busy is the only back-pressure on commands.
module banked_stack_register_file_unit #(
    parameter int unsigned REGISTER_COUNT = bsrf_pkg::DEFAULT_REGISTER_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bsrf_pkg::t_in_beat i_cmd,
    output logic               o_strobe,
    output bsrf_pkg::t_out_beat o_result
);
    import bsrf_pkg::*;

    localparam int unsigned AW = $clog2(REGISTER_COUNT);
    localparam logic [AW-1:0] SP_ADDR = AW'(SP_INDEX);
    localparam logic [AW-1:0] PC_ADDR = AW'(PC_INDEX);

    t_state            r_state, n_state;
    t_in_beat          r_cmd;
    logic              r_idx_ok;
    logic [WORD_W-1:0] r_psr, n_psr;
    logic [WORD_W-1:0] r_ctrl, n_ctrl;
    logic [WORD_W-1:0] r_msp, n_msp;
    logic [WORD_W-1:0] r_psp, n_psp;
    t_out_beat         r_result, n_result;
    logic              r_strobe, n_strobe;

    logic              accept;
    logic              in_idx_ok;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     cmd_addr;
    logic              was_process;
    logic              to_process;

    assign accept    = start && !busy;
    assign in_idx_ok = (i_cmd.reg_index < INDEX_W'(REGISTER_COUNT));
    assign cmd_addr  = r_cmd.reg_index[AW-1:0];

    // General register storage
    bsrf_gpr_bank #(
        .REGISTER_COUNT (REGISTER_COUNT),
        .AW             (AW)
    ) u_gpr_bank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // State register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_psr    <= '0;
            r_ctrl   <= '0;
            r_msp    <= '0;
            r_psp    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_psr    <= n_psr;
            r_ctrl   <= n_ctrl;
            r_msp    <= n_msp;
            r_psp    <= n_psp;
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_cmd;
            r_idx_ok <= in_idx_ok;
        end
        r_result <= n_result;
    end

    assign was_process = r_ctrl[SPSEL_BIT];
    assign to_process  = r_cmd.write_value[SPSEL_BIT];

    // Sequencer: issue read on accept (GPR reads, control writes), execute and write back next cycle
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_result = r_result;
        n_psr    = r_psr;
        n_ctrl   = r_ctrl;
        n_msp    = r_msp;
        n_psp    = r_psp;
        busy     = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = i_cmd.reg_index[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = cmd_addr;
        wr_data  = r_cmd.write_value;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                    if (i_cmd.kind == KIND_WR_CTRL) begin
                        rd_en   = 1'b1;
                        rd_addr = SP_ADDR;
                    end else if (i_cmd.kind == KIND_RD_GPR) begin
                        rd_en   = in_idx_ok;
                    end
                end
            end
            ST_EXEC: begin
                busy       = 1'b1;
                n_state    = ST_IDLE;
                n_strobe   = 1'b1;
                n_result   = '{read_value: '0, status: STATUS_OK};
                unique case (r_cmd.kind)
                    KIND_RD_GPR: begin
                        if (!r_idx_ok) begin
                            n_result.status = STATUS_BAD_INDEX;
                        end else if (cmd_addr == PC_ADDR) begin
                            n_result.read_value = rd_data + PC_OFFSET;
                        end else begin
                            n_result.read_value = rd_data;
                        end
                    end
                    KIND_WR_GPR: begin
                        if (!r_idx_ok) begin
                            n_result.status = STATUS_BAD_INDEX;
                        end else begin
                            wr_en = 1'b1;
                            if (cmd_addr == SP_ADDR) begin
                                wr_data = r_cmd.write_value & ~SP_LOW_MASK;
                            end
                        end
                    end
                    KIND_RD_PSR: begin
                        n_result.read_value = r_psr;
                    end
                    KIND_WR_PSR: begin
                        n_psr = r_cmd.write_value;
                    end
                    KIND_RD_CTRL: begin
                        n_result.read_value = r_ctrl;
                    end
                    KIND_WR_CTRL: begin
                        // Stack select flip: bank live SP, load the other one
                        n_ctrl  = r_cmd.write_value;
                        wr_addr = SP_ADDR;
                        if (was_process && !to_process) begin
                            n_psp   = rd_data;
                            wr_en   = 1'b1;
                            wr_data = r_msp;
                        end else if (!was_process && to_process) begin
                            n_msp   = rd_data;
                            wr_en   = 1'b1;
                            wr_data = r_psp;
                        end
                    end
                    default: begin
                        // undefined kinds: no state change, zero result
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Every accepted command holds busy for its execute cycle
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted command did not enter execute");

    // Execute cycle always yields exactly one result strobe
    a_exec_then_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("execute cycle did not produce a result");

    // A result only follows an execute cycle
    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a command");

    // Banking only happens on a control write
    a_bank_only_on_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_cmd.kind != KIND_WR_CTRL) |=> ($stable(r_msp) && $stable(r_psp)))
        else $error("stack store changed outside a control write");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the banked stack register file unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsrf_pkg::*;

    // Kind codes outside the defined set; the block must leave state alone
    localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 3'd7;
    localparam logic [WORD_W-1:0] ALL_ONES      = '1;
    localparam int unsigned       REG_COUNT     = DEFAULT_REGISTER_COUNT;
    localparam int unsigned       RANDOM_BEATS  = 2000;
    localparam int unsigned       IDLE_LIMIT    = 2000;

    // Tracks architectural state and checks each result beat against it
    class reg_bank_checker;
        logic [WORD_W-1:0] gpr [REG_COUNT];
        logic [WORD_W-1:0] main_sp;
        logic [WORD_W-1:0] process_sp;
        logic [WORD_W-1:0] psr;
        logic [WORD_W-1:0] ctrl;
        t_out_beat         expected_replies[$];
        int unsigned       errors;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            main_sp    = '0;
            process_sp = '0;
            psr        = '0;
            ctrl       = '0;
            errors     = 0;
        endfunction

        // Apply one accepted command beat and queue the reply it must produce
        function void record_access(t_in_beat cmd);
            t_out_beat         reply;
            logic [WORD_W-1:0] value;
            logic              was_process;
            logic              to_process;
            reply.read_value = '0;
            reply.status     = STATUS_OK;
            value            = cmd.write_value;
            case (cmd.kind)
                KIND_RD_GPR: begin
                    if (cmd.reg_index >= REG_COUNT) begin
                        reply.status = STATUS_BAD_INDEX;
                    end else begin
                        reply.read_value = gpr[cmd.reg_index];
                        if (cmd.reg_index == PC_INDEX)
                            reply.read_value = reply.read_value + PC_OFFSET;
                    end
                end
                KIND_WR_GPR: begin
                    if (cmd.reg_index >= REG_COUNT) begin
                        reply.status = STATUS_BAD_INDEX;
                    end else begin
                        if (cmd.reg_index == SP_INDEX)
                            value = value & ~SP_LOW_MASK;
                        gpr[cmd.reg_index] = value;
                    end
                end
                KIND_RD_PSR:  reply.read_value = psr;
                KIND_WR_PSR:  psr = value;
                KIND_RD_CTRL: reply.read_value = ctrl;
                KIND_WR_CTRL: begin
                    // A flip of the stack-select bit swaps the live SP with its bank
                    was_process = ctrl[SPSEL_BIT];
                    to_process  = value[SPSEL_BIT];
                    if (was_process && !to_process) begin
                        process_sp   = gpr[SP_INDEX];
                        gpr[SP_INDEX] = main_sp;
                    end else if (!was_process && to_process) begin
                        main_sp      = gpr[SP_INDEX];
                        gpr[SP_INDEX] = process_sp;
                    end
                    ctrl = value;
                end
                default: ;
            endcase
            expected_replies.push_back(reply);
        endfunction

        // Compare one result beat with the oldest outstanding reply
        function void check_reply(t_out_beat got);
            t_out_beat want;
            if (expected_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual value=%h status=%0b",
                         $time, got.read_value, got.status);
                return;
            end
            want = expected_replies.pop_front();
            if (got.read_value !== want.read_value) begin
                errors++;
                $display("%0t: read_value mismatch: expected %h, actual %h",
                         $time, want.read_value, got.read_value);
            end
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0b, actual %0b",
                         $time, want.status, got.status);
            end
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction
    endclass

    bit          i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_beat    i_cmd;
    logic        o_strobe;
    t_out_beat   o_result;

    reg_bank_checker checker_h;
    int unsigned     burst_left;
    int unsigned     idle_cycles;

    banked_stack_register_file_unit #(
        .REGISTER_COUNT(REG_COUNT)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            checker_h.check_reply(o_result);
    end

    // Watchdog: too many cycles without an accepted beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Drive one command beat; a gap of random length may open a new burst
    task automatic send_beat(input t_in_beat cmd);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
        checker_h.record_access(cmd);
        burst_left--;
    endtask

    function automatic t_in_beat make_beat(logic [KIND_W-1:0] kind,
                                           logic [INDEX_W-1:0] idx,
                                           logic [WORD_W-1:0] value);
        t_in_beat b;
        b.kind        = kind;
        b.reg_index   = idx;
        b.write_value = value;
        return b;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Valid register numbers, biased toward SP and PC
    function automatic logic [INDEX_W-1:0] valid_index();
        case ($urandom_range(0, 4))
            0:       return INDEX_W'(SP_INDEX);
            1:       return INDEX_W'(PC_INDEX);
            default: return INDEX_W'($urandom_range(0, REG_COUNT - 1));
        endcase
    endfunction

    // Random access mix: mostly valid GPR traffic and stack-select toggling
    function automatic t_in_beat random_access();
        int unsigned pick;
        logic [INDEX_W-1:0] any_idx;
        pick    = $urandom_range(0, 99);
        any_idx = INDEX_W'($urandom_range(0, 255));
        if (pick < 28)
            return make_beat(KIND_RD_GPR, valid_index(), random_word());
        else if (pick < 52)
            return make_beat(KIND_WR_GPR, valid_index(), random_word());
        else if (pick < 58)
            return make_beat(KIND_RD_PSR, any_idx, random_word());
        else if (pick < 64)
            return make_beat(KIND_WR_PSR, any_idx, random_word());
        else if (pick < 71)
            return make_beat(KIND_RD_CTRL, any_idx, random_word());
        else if (pick < 88)
            return make_beat(KIND_WR_CTRL, any_idx, random_word());
        else if (pick < 96)
            return make_beat(($urandom_range(0, 1) != 0) ? KIND_WR_GPR : KIND_RD_GPR,
                             INDEX_W'($urandom_range(REG_COUNT, 255)), random_word());
        else
            return make_beat(($urandom_range(0, 1) != 0) ? KIND_UNDEF_HI : KIND_UNDEF_LO,
                             any_idx, random_word());
    endfunction

    initial begin
        checker_h   = new();
        burst_left  = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset values, field extremes, PC wrap, SP alignment,
        // bad indexes, undefined kinds and both stack-select transitions
        send_beat(make_beat(KIND_RD_GPR,  8'd0,   '0));
        send_beat(make_beat(KIND_RD_PSR,  8'd0,   '0));
        send_beat(make_beat(KIND_RD_CTRL, 8'd0,   '0));
        send_beat(make_beat(KIND_WR_GPR,  8'd0,   ALL_ONES));
        send_beat(make_beat(KIND_RD_GPR,  8'd0,   '0));
        send_beat(make_beat(KIND_WR_GPR,  8'd15,  32'hFFFF_FFFE));
        send_beat(make_beat(KIND_RD_GPR,  8'd15,  '0));
        send_beat(make_beat(KIND_WR_GPR,  8'd13,  ALL_ONES));
        send_beat(make_beat(KIND_RD_GPR,  8'd13,  '0));
        send_beat(make_beat(KIND_RD_GPR,  8'd16,  ALL_ONES));
        send_beat(make_beat(KIND_WR_GPR,  8'd255, ALL_ONES));
        send_beat(make_beat(KIND_RD_GPR,  8'd255, '0));
        send_beat(make_beat(KIND_WR_PSR,  8'd255, ALL_ONES));
        send_beat(make_beat(KIND_RD_PSR,  8'd0,   '0));
        send_beat(make_beat(KIND_WR_CTRL, 8'd0,   32'h0000_0002));
        send_beat(make_beat(KIND_RD_GPR,  8'd13,  '0));
        send_beat(make_beat(KIND_WR_GPR,  8'd13,  32'h1234_5677));
        send_beat(make_beat(KIND_WR_CTRL, 8'd0,   ALL_ONES));
        send_beat(make_beat(KIND_RD_CTRL, 8'd0,   '0));
        send_beat(make_beat(KIND_WR_CTRL, 8'd0,   '0));
        send_beat(make_beat(KIND_RD_GPR,  8'd13,  '0));
        send_beat(make_beat(KIND_WR_CTRL, 8'd0,   32'h0000_0002));
        send_beat(make_beat(KIND_RD_GPR,  8'd13,  '0));
        send_beat(make_beat(KIND_UNDEF_LO, 8'd13, ALL_ONES));
        send_beat(make_beat(KIND_UNDEF_HI, 8'd255, ALL_ONES));

        // Random traffic
        repeat (RANDOM_BEATS) send_beat(random_access());

        @(negedge i_clk);
        start <= 1'b0;

        // Drain outstanding results; the watchdog bounds this wait
        while (checker_h.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (checker_h.errors == 0 && checker_h.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ banked_stack_register_file_unit.f @@
rtl/bsrf_pkg.sv
rtl/bsrf_gpr_bank.sv
rtl/banked_stack_register_file_unit.sv
tb/sv/testbench.sv
